/* design/nec_ir_pulse_decoder_defines.svh */
// Assertion macros used by the checker file of the NEC pulse decoder.
`ifndef NEC_IR_PULSE_DECODER_DEFINES_SVH
`define NEC_IR_PULSE_DECODER_DEFINES_SVH

// Same-cycle implication, checked while reset is released.
`define NIPD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while reset is released.
`define NIPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/nipd_pkg.sv */
`default_nettype none

package nipd_pkg;

    // Field widths.
    localparam int KIND_W  = 2;
    localparam int WIDTH_W = 16;
    localparam int BYTE_W  = 8;
    localparam int SHIFT_W = 32;
    localparam int TICK_W  = 4;
    localparam int OUT_DATA_W = 24;

    // Default depth of the queue between front and back.
    localparam int QUEUE_DEPTH_DEF = 2;

    // Request kinds as they arrive on tuser.
    localparam logic [KIND_W-1:0] KIND_RISE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FALL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SCAN = 2'd3;

    // Pulse width windows in microseconds (exclusive bounds).
    localparam logic [WIDTH_W-1:0] ZERO_LO = 16'd300;
    localparam logic [WIDTH_W-1:0] ZERO_HI = 16'd800;
    localparam logic [WIDTH_W-1:0] ONE_LO  = 16'd1400;
    localparam logic [WIDTH_W-1:0] ONE_HI  = 16'd1800;
    localparam logic [WIDTH_W-1:0] REP_LO  = 16'd2000;
    localparam logic [WIDTH_W-1:0] REP_HI  = 16'd3000;
    localparam logic [WIDTH_W-1:0] LEAD_LO = 16'd4200;
    localparam logic [WIDTH_W-1:0] LEAD_HI = 16'd4700;

    // Ticks of 10 ms before the leader times out.
    localparam logic [TICK_W-1:0] TICK_LIMIT = 4'd14;

    // Classified operations handed from front to back.
    typedef logic [2:0] nipd_op_t;
    localparam nipd_op_t OP_ARM       = 3'd0;
    localparam nipd_op_t OP_FALL_NONE = 3'd1;
    localparam nipd_op_t OP_FALL_ZERO = 3'd2;
    localparam nipd_op_t OP_FALL_ONE  = 3'd3;
    localparam nipd_op_t OP_FALL_REP  = 3'd4;
    localparam nipd_op_t OP_FALL_LEAD = 3'd5;
    localparam nipd_op_t OP_TICK      = 3'd6;
    localparam nipd_op_t OP_SCAN      = 3'd7;

    // One result word; packed so that key_code sits in the lowest bits.
    typedef struct packed {
        logic              frame_ready;
        logic              leader_active;
        logic [BYTE_W-1:0] repeat_count;
        logic [BYTE_W-1:0] key_code;
    } nipd_result_t;

    localparam int RESULT_W = $bits(nipd_result_t);

endpackage

`default_nettype wire

/* design/nipd_front.sv */
`default_nettype none

module nipd_front
    import nipd_pkg::*;
(
    input  wire logic [KIND_W-1:0]  req_type,
    input  wire logic [WIDTH_W-1:0] high_width,
    output nipd_op_t                op
);

    logic in_zero;
    logic in_one;
    logic in_rep;
    logic in_lead;

    // Window checks on the measured high width.
    assign in_zero = (high_width > ZERO_LO) && (high_width < ZERO_HI);
    assign in_one  = (high_width > ONE_LO)  && (high_width < ONE_HI);
    assign in_rep  = (high_width > REP_LO)  && (high_width < REP_HI);
    assign in_lead = (high_width > LEAD_LO) && (high_width < LEAD_HI);

    // Turn the request kind and width window into one operation code.
    always_comb begin
        op = OP_ARM;
        unique case (req_type)
            KIND_RISE: op = OP_ARM;
            KIND_FALL: begin
                priority if (in_zero) op = OP_FALL_ZERO;
                else if (in_one)      op = OP_FALL_ONE;
                else if (in_rep)      op = OP_FALL_REP;
                else if (in_lead)     op = OP_FALL_LEAD;
                else                  op = OP_FALL_NONE;
            end
            KIND_TICK: op = OP_TICK;
            KIND_SCAN: op = OP_SCAN;
            default:   op = OP_ARM;
        endcase
    end

endmodule

`default_nettype wire

/* design/nipd_queue.sv */
`default_nettype none

module nipd_queue
    import nipd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push,
    input  wire nipd_op_t push_op,
    output logic          full,
    input  wire logic     pop,
    output logic          not_empty,
    output nipd_op_t      head_op
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    nipd_op_t         slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head_op   = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue slots hold payload only.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

/* design/nipd_back.sv */
`default_nettype none

module nipd_back
    import nipd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [BYTE_W-1:0] cfg_wr_data,
    input  wire logic              op_valid,
    input  wire nipd_op_t          op,
    output logic                   op_pop,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output nipd_result_t           res
);

    logic [BYTE_W-1:0]  addr_reg;
    logic               leader_reg,  leader_next;
    logic               ready_reg,   ready_next;
    logic               armed_reg,   armed_next;
    logic [TICK_W-1:0]  tick_reg,    tick_next;
    logic [SHIFT_W-1:0] shift_reg,   shift_next;
    logic [BYTE_W-1:0]  repeats_reg, repeats_next;
    logic               res_valid_reg;
    nipd_result_t       res_reg,     res_next;

    logic [BYTE_W-1:0] a_byte, na_byte, c_byte, nc_byte;
    logic [BYTE_W-1:0] key;

    // Take an operation whenever the output register is free or being drained.
    assign op_pop    = op_valid && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Frame bytes, first received bit at bit 0.
    assign a_byte  = shift_reg[BYTE_W-1:0];
    assign na_byte = shift_reg[2*BYTE_W-1:BYTE_W];
    assign c_byte  = shift_reg[3*BYTE_W-1:2*BYTE_W];
    assign nc_byte = shift_reg[4*BYTE_W-1:3*BYTE_W];

    // State update for one operation.
    always_comb begin
        leader_next  = leader_reg;
        ready_next   = ready_reg;
        armed_next   = armed_reg;
        tick_next    = tick_reg;
        shift_next   = shift_reg;
        repeats_next = repeats_reg;
        key          = '0;
        unique case (op)
            OP_ARM: armed_next = 1'b1;
            OP_FALL_NONE: armed_next = 1'b0;
            OP_FALL_ZERO: begin
                armed_next = 1'b0;
                if (armed_reg && leader_reg) begin
                    shift_next = {1'b0, shift_reg[SHIFT_W-1:1]};
                end
            end
            OP_FALL_ONE: begin
                armed_next = 1'b0;
                if (armed_reg && leader_reg) begin
                    shift_next = {1'b1, shift_reg[SHIFT_W-1:1]};
                end
            end
            OP_FALL_REP: begin
                armed_next = 1'b0;
                if (armed_reg && leader_reg) begin
                    repeats_next = repeats_reg + 1'b1;
                    tick_next    = '0;
                end
            end
            OP_FALL_LEAD: begin
                armed_next = 1'b0;
                if (armed_reg && !leader_reg) begin
                    leader_next  = 1'b1;
                    repeats_next = '0;
                end
            end
            OP_TICK: begin
                if (leader_reg) begin
                    armed_next = 1'b0;
                    if (tick_reg == '0) begin
                        ready_next = 1'b1;
                    end
                    if (tick_reg < TICK_LIMIT) begin
                        tick_next = tick_reg + 1'b1;
                    end else begin
                        leader_next = 1'b0;
                        tick_next   = '0;
                    end
                end
            end
            OP_SCAN: begin
                if (ready_reg) begin
                    if ((a_byte == ~na_byte) && (a_byte == addr_reg)
                            && (c_byte == ~nc_byte)) begin
                        key = c_byte;
                    end
                    if ((key == '0) || !leader_reg) begin
                        ready_next   = 1'b0;
                        repeats_next = '0;
                    end
                end
            end
            default: armed_next = armed_reg;
        endcase

        res_next.key_code      = key;
        res_next.repeat_count  = repeats_next;
        res_next.leader_active = leader_next;
        res_next.frame_ready   = ready_next;
    end

    // Decoder state and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg      <= '0;
            leader_reg    <= 1'b0;
            ready_reg     <= 1'b0;
            armed_reg     <= 1'b0;
            tick_reg      <= '0;
            shift_reg     <= '0;
            repeats_reg   <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                addr_reg <= cfg_wr_data;
            end
            if (op_pop) begin
                leader_reg  <= leader_next;
                ready_reg   <= ready_next;
                armed_reg   <= armed_next;
                tick_reg    <= tick_next;
                shift_reg   <= shift_next;
                repeats_reg <= repeats_next;
            end
            if (op_pop) begin
                res_valid_reg <= 1'b1;
            end else if (res_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Result word register.
    always_ff @(posedge aclk) begin
        if (op_pop) begin
            res_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

/* design/nec_ir_pulse_decoder.sv */
// NEC infrared pulse decoder.
// Input words arrive on s_tvalid/s_tready: s_tuser carries the request kind
// (rising edge, falling edge, 10 ms tick, scan request) and s_tdata the
// measured high width in microseconds, which only a falling edge uses.
// Every input word yields exactly one result word on m_tvalid/m_tready with
// the key code (nonzero only on a passing scan), the repeat count and the
// leader and frame-ready flags after that request.
// The expected address byte is written through cfg_wr_en/cfg_wr_data; the
// user must write it only while the decoder is idle; the block does not enforce it.
// A front stage classifies each word and writes it to a small queue; a back
// stage applies it to the decoder state and loads the output register.
// m_tvalid rises once the queued word has been applied and the output register
// loaded; one word per cycle is sustained while m_tready stays high.
// A stalled m_tready holds the output word; the queue absorbs up to
// QUEUE_DEPTH words before s_tready drops.
// Synchronous active-low reset clears the decoder state, the address, the
// queue and the output valid.
`default_nettype none

module nec_ir_pulse_decoder
    import nipd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [BYTE_W-1:0]     cfg_wr_data,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [WIDTH_W-1:0]    s_tdata,   // [15:0] high_width
    input  wire logic [KIND_W-1:0]     s_tuser,   // [1:0] req_type
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [7:0] key_code, [15:8] repeat_count, [16] leader_active,
    // [17] frame_ready, [23:18] zero
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    nipd_op_t     front_op;
    nipd_op_t     head_op;
    logic         q_full;
    logic         q_not_empty;
    logic         q_pop;
    logic         push;
    nipd_result_t res;

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    nipd_front u_front (
        .req_type   (s_tuser),
        .high_width (s_tdata),
        .op         (front_op)
    );

    nipd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_op   (front_op),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_op   (head_op)
    );

    nipd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .op_valid    (q_not_empty),
        .op          (head_op),
        .op_pop      (q_pop),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res         (res)
    );

    // Pad the result word to whole bytes.
    assign m_tdata = {(OUT_DATA_W - RESULT_W)'(0), res};

endmodule

`default_nettype wire

/* design/nipd_checker.sv */
`default_nettype none
`include "nec_ir_pulse_decoder_defines.svh"

module nipd_checker
    import nipd_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata
);

    logic              key_nz;
    logic [BYTE_W-1:0] rep_cnt;
    logic              leader_on;
    logic              ready_on;

    assign key_nz    = (m_tdata[BYTE_W-1:0] != '0);
    assign rep_cnt   = m_tdata[2*BYTE_W-1:BYTE_W];
    assign leader_on = m_tdata[2*BYTE_W];
    assign ready_on  = m_tdata[2*BYTE_W+1];

    // A stalled result word holds its value.
    `NIPD_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed while stalled")

    // A passing scan keeps the frame ready exactly when the leader is still active.
    `NIPD_ASSERT_NOW(a_key_ready, aclk, aresetn, m_tvalid && key_nz, leader_on == ready_on, "key delivered with inconsistent ready flag")

    // A passing scan after the leader timed out clears the repeat count.
    `NIPD_ASSERT_NOW(a_key_repeat, aclk, aresetn, m_tvalid && key_nz && !leader_on, rep_cnt == '0, "repeat count kept after expired leader")

endmodule

bind nec_ir_pulse_decoder nipd_checker u_nipd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import nipd_pkg::*;

    // One pending input word: request kind and measured width.
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [WIDTH_W-1:0] width;
    } ir_word_t;

    logic                  aclk;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [BYTE_W-1:0]     cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [WIDTH_W-1:0]    s_tdata     = '0;
    logic [KIND_W-1:0]     s_tuser     = '0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    // Words waiting to be driven and decoder results still due.
    ir_word_t     pending_q[$];
    nipd_result_t due_results_q[$];
    ir_word_t     next_word;
    nipd_result_t want_res;
    nipd_result_t got_res;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           queued_words  = 0;
    int           errors        = 0;

    // Shadow copy of the decoder state and the address register.
    logic [BYTE_W-1:0]  dev_addr;
    logic               leader_seen;
    logic               frame_rdy;
    logic               edge_armed;
    logic [TICK_W-1:0]  tick_cnt;
    logic [SHIFT_W-1:0] shift_reg;
    logic [BYTE_W-1:0]  repeat_cnt;

    nec_ir_pulse_decoder u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),   // [15:0] high_width
        .s_tuser    (s_tuser),   // [1:0] req_type
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        // [7:0] key_code, [15:8] repeat_count, [16] leader_active,
        // [17] frame_ready, [23:18] zero
        .m_tdata    (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Run limit, far above the slowest legal run.
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic in_window(input logic [WIDTH_W-1:0] w,
                                       input logic [WIDTH_W-1:0] lo,
                                       input logic [WIDTH_W-1:0] hi);
        return (w > lo) && (w < hi);
    endfunction

    // Apply one accepted word to the shadow decoder and queue its result.
    task automatic decode_word(input logic [KIND_W-1:0] kind,
                               input logic [WIDTH_W-1:0] w);
        nipd_result_t res;
        logic [BYTE_W-1:0] key;
        key = '0;
        case (kind)
            KIND_RISE: begin
                edge_armed = 1'b1;
            end
            KIND_FALL: begin
                if (edge_armed) begin
                    if (leader_seen) begin
                        if (in_window(w, ZERO_LO, ZERO_HI)) begin
                            shift_reg = {1'b0, shift_reg[SHIFT_W-1:1]};
                        end else if (in_window(w, ONE_LO, ONE_HI)) begin
                            shift_reg = {1'b1, shift_reg[SHIFT_W-1:1]};
                        end else if (in_window(w, REP_LO, REP_HI)) begin
                            repeat_cnt = repeat_cnt + 1'b1;
                            tick_cnt   = '0;
                        end
                    end else if (in_window(w, LEAD_LO, LEAD_HI)) begin
                        leader_seen = 1'b1;
                        repeat_cnt  = '0;
                    end
                end
                edge_armed = 1'b0;
            end
            KIND_TICK: begin
                if (leader_seen) begin
                    edge_armed = 1'b0;
                    if (tick_cnt == '0) frame_rdy = 1'b1;
                    if (tick_cnt < TICK_LIMIT) begin
                        tick_cnt = tick_cnt + 1'b1;
                    end else begin
                        leader_seen = 1'b0;
                        tick_cnt    = '0;
                    end
                end
            end
            default: begin
                if (frame_rdy) begin
                    if (shift_reg[7:0] == ~shift_reg[15:8] && shift_reg[7:0] == dev_addr &&
                        shift_reg[23:16] == ~shift_reg[31:24]) begin
                        key = shift_reg[23:16];
                    end
                    if (key == '0 || !leader_seen) begin
                        frame_rdy  = 1'b0;
                        repeat_cnt = '0;
                    end
                end
            end
        endcase
        res.key_code      = key;
        res.repeat_count  = repeat_cnt;
        res.leader_active = leader_seen;
        res.frame_ready   = frame_rdy;
        due_results_q.push_back(res);
    endtask

    // Driver: presents pending words and feeds each accepted one to the shadow decoder.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                decode_word(s_tuser, s_tdata);
            end
            if (!s_tvalid || s_tready) begin
                if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_word = pending_q.pop_front();
                    s_tuser  <= next_word.kind;
                    s_tdata  <= next_word.width;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: throttles the result side and checks every result word.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            if (m_tvalid && m_tready) begin
                got_res = nipd_result_t'(m_tdata[RESULT_W-1:0]);
                if (due_results_q.size() == 0) begin
                    $error("result word 0x%h with nothing expected", m_tdata);
                    errors++;
                end else begin
                    want_res = due_results_q.pop_front();
                    if (got_res.key_code !== want_res.key_code) begin
                        $error("key_code: expected %0d, got %0d",
                               want_res.key_code, got_res.key_code);
                        errors++;
                    end
                    if (got_res.repeat_count !== want_res.repeat_count) begin
                        $error("repeat_count: expected %0d, got %0d",
                               want_res.repeat_count, got_res.repeat_count);
                        errors++;
                    end
                    if (got_res.leader_active !== want_res.leader_active) begin
                        $error("leader_active: expected %0d, got %0d",
                               want_res.leader_active, got_res.leader_active);
                        errors++;
                    end
                    if (got_res.frame_ready !== want_res.frame_ready) begin
                        $error("frame_ready: expected %0d, got %0d",
                               want_res.frame_ready, got_res.frame_ready);
                        errors++;
                    end
                    if (m_tdata[OUT_DATA_W-1:RESULT_W] !== '0) begin
                        $error("padding: expected 0, got 0x%h",
                               m_tdata[OUT_DATA_W-1:RESULT_W]);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic queue_word(input logic [KIND_W-1:0] kind,
                              input logic [WIDTH_W-1:0] w);
        ir_word_t wd;
        wd.kind  = kind;
        wd.width = w;
        pending_q.push_back(wd);
        queued_words++;
    endtask

    // A rising edge with a random payload, then the falling edge with its width.
    task automatic queue_pulse(input logic [WIDTH_W-1:0] w);
        queue_word(KIND_RISE, WIDTH_W'($urandom()));
        queue_word(KIND_FALL, w);
    endtask

    function automatic logic [WIDTH_W-1:0] width_in(input logic [WIDTH_W-1:0] lo,
                                                   input logic [WIDTH_W-1:0] hi);
        return WIDTH_W'($urandom_range(int'(hi) - 1, int'(lo) + 1));
    endfunction

    task automatic queue_noise();
        queue_word(KIND_W'($urandom_range(0, 3)), WIDTH_W'($urandom()));
    endtask

    task automatic queue_ticks(input int n);
        repeat (n) queue_word(KIND_TICK, WIDTH_W'($urandom()));
    endtask

    task automatic queue_scan();
        queue_word(KIND_SCAN, WIDTH_W'($urandom()));
    endtask

    // Leader pulse, then data bits LSB first with occasional noise in between.
    task automatic queue_frame_bits(input logic [SHIFT_W-1:0] bits, input int nbits);
        queue_pulse(width_in(LEAD_LO, LEAD_HI));
        for (int i = 0; i < nbits; i++) begin
            if ($urandom_range(0, 39) == 0) queue_noise();
            if (bits[i % SHIFT_W]) queue_pulse(width_in(ONE_LO, ONE_HI));
            else queue_pulse(width_in(ZERO_LO, ZERO_HI));
        end
    endtask

    // One frame exchange: usually a timeout of any old leader, then frame, scans, repeats.
    task automatic queue_nec_frame(input logic [BYTE_W-1:0] addr);
        logic [BYTE_W-1:0]  a;
        logic [BYTE_W-1:0]  c;
        logic [SHIFT_W-1:0] bits;
        int                 nbits;
        a = ($urandom_range(0, 7) == 0) ? BYTE_W'($urandom()) : addr;
        c = BYTE_W'($urandom());
        bits = {~c, c, ~a, a};
        if ($urandom_range(0, 5) == 0) bits[$urandom_range(0, 31)] ^= 1'b1;
        nbits = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : SHIFT_W;
        // Usually let the old leader expire so that the new one is recognized.
        if ($urandom_range(0, 5) != 0) queue_ticks($urandom_range(15, 17));
        queue_frame_bits(bits, nbits);
        queue_ticks($urandom_range(0, 2));
        queue_scan();
        repeat ($urandom_range(0, 3)) begin
            queue_pulse(width_in(REP_LO, REP_HI));
            if ($urandom_range(0, 1) == 0) queue_ticks(1);
            if ($urandom_range(0, 1) == 0) queue_scan();
        end
        // Sometimes scan only after the leader has timed out.
        if ($urandom_range(0, 2) == 0) begin
            queue_ticks(15);
            queue_scan();
        end
        repeat ($urandom_range(0, 3)) queue_noise();
    endtask

    // Wait until every word has been taken and every result checked.
    task automatic wait_drained();
        while (pending_q.size() != 0 || s_tvalid || due_results_q.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_address(input logic [BYTE_W-1:0] a);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= a;
        dev_addr     = a;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(negedge aclk);
    endtask

    // Stimulus: three idling phases of random frames, with directed checks in two.
    initial begin
        dev_addr    = '0;
        leader_seen = 1'b0;
        frame_rdy   = 1'b0;
        edge_armed  = 1'b0;
        tick_cnt    = '0;
        shift_reg   = '0;
        repeat_cnt  = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 21;
                    recv_idle_pct = 82;
                    write_address(8'h00);
                end
                1: begin
                    send_idle_pct = 82;
                    recv_idle_pct = 21;
                    write_address(8'hFF);
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    write_address(BYTE_W'($urandom_range(1, 254)));
                end
            endcase
            queued_words = 0;

            if (phase == 0) begin
                // Tick without leader, scan while not ready, fall while not armed.
                queue_word(KIND_TICK, 16'hFFFF);
                queue_word(KIND_SCAN, 16'h0000);
                queue_word(KIND_FALL, 16'd4500);
                // Widths in no window, the leader edge, then a leader.
                queue_pulse(16'd0);
                queue_pulse(16'd4200);
                queue_pulse(16'd4699);
                // A leader while one is active is not recognized.
                queue_pulse(16'd4201);
                // Window edges for zero, one and repeat.
                queue_pulse(16'd300);
                queue_pulse(16'd301);
                queue_pulse(16'd1401);
                queue_pulse(16'd1799);
                queue_pulse(16'd2001);
                queue_pulse(16'd2999);
                queue_pulse(16'hFFFF);
                queue_word(KIND_TICK, 16'h0000);
                queue_scan();
            end

            if (phase == 2) begin
                // Enough repeat codes after one good frame to wrap the count.
                logic [BYTE_W-1:0] c;
                c = BYTE_W'($urandom_range(1, 255));
                queue_ticks(15);
                queue_frame_bits({~c, c, ~dev_addr, dev_addr}, SHIFT_W);
                repeat (257) begin
                    queue_pulse(width_in(REP_LO, REP_HI));
                    if ($urandom_range(0, 63) == 0) queue_ticks(1);
                end
                queue_ticks(1);
                queue_scan();
            end

            while (queued_words < 320) begin
                if ($urandom_range(0, 4) == 0) queue_noise();
                else queue_nec_frame(dev_addr);
            end
            wait_drained();
        end

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
